>>> hdl/array_list_search_remove_assert.svh
// Assertion macros for the array list search and remove block.
`ifndef ARRAY_LIST_SEARCH_REMOVE_ASSERT_SVH
`define ARRAY_LIST_SEARCH_REMOVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define ALSR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("array_list_search_remove: assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define ALSR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("array_list_search_remove: assertion failed");

`endif

>>> hdl/alsr_pkg.sv
// Package: types, constants and control bundles of the array list search and remove block.
package alsr_pkg;

  localparam int LIST_DEPTH = 128;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int AGE_W   = 8;
  localparam int ST_W    = 2;
  localparam int POS_W   = 7;
  localparam int COUNT_W = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] key_in;
    logic [AGE_W-1:0]        age_in;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [POS_W-1:0]   position;
    logic [AGE_W-1:0]   entry_age;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load_item;
    logic clr_idx;
    logic inc_idx;
    logic rd_en;
    logic scan_cmp;
    logic shift_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            hit;
    logic            more;
  } sts_t;

endpackage

>>> hdl/alsr_ram.sv
// Generic simple dual-port RAM with registered read.
module alsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/alsr_datapath.sv
// Datapath: entry RAM, count, scan index, match logic and result register.
module alsr_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  alsr_pkg::cmd_t     cmd,
  input  alsr_pkg::in_item_t in_data,
  output alsr_pkg::sts_t     sts,
  output alsr_pkg::out_item_t out_data
);
  import alsr_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W:0]   idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic             found_r;
  in_item_t         item_r;
  logic [IDX_W-1:0] pos_r;
  logic [AGE_W-1:0] age_r;
  out_item_t        out_r, out_nxt;

  logic             full;
  logic             hit;
  logic             do_insert;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  entry_t           ram_wr_data;
  entry_t           ram_rd_data;

  assign idx_inc   = {1'b0, idx_r} + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign full      = (count_r == CNT_W'(LIST_DEPTH));
  assign hit       = (ram_rd_data.key == item_r.key_in);
  assign do_insert = cmd.finish && (item_r.operation == OP_INSERT) && !full;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = idx_dec[IDX_W-1:0];
    ram_wr_data = ram_rd_data;
    if (cmd.shift_wr) begin
      ram_wr_en = 1'b1;
    end else if (do_insert) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = count_r[IDX_W-1:0];
      ram_wr_data = '{key: item_r.key_in, age: item_r.age_in};
    end
  end

  alsr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LIST_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    count_nxt = count_r;
    out_nxt   = '{status: ST_NOT_FOUND, position: '0, entry_age: '0, entry_count: '0};
    case (item_r.operation)
      OP_INSERT: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status   = ST_OK;
          out_nxt.position = POS_W'(count_r);
          count_nxt        = count_r + 1'b1;
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        if (found_r) begin
          out_nxt.status    = ST_OK;
          out_nxt.position  = POS_W'(pos_r);
          out_nxt.entry_age = age_r;
          if (item_r.operation == OP_REMOVE) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.entry_count = COUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.clr_idx) begin
        idx_r <= '0;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_inc[CNT_W-1:0];
      end
      if (cmd.load_item) begin
        found_r <= 1'b0;
      end else if (cmd.scan_cmp && hit) begin
        found_r <= 1'b1;
      end
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.scan_cmp && hit) begin
      pos_r <= idx_r[IDX_W-1:0];
      age_r <= ram_rd_data.age;
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
    end
  end

  assign sts.op       = item_r.operation;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.hit      = hit;
  assign sts.more     = (idx_inc < {1'b0, count_r});
  assign out_data     = out_r;

endmodule

>>> hdl/alsr_ctrl.sv
// Controller: sequences insert, scan and shift steps and owns both handshakes.
module alsr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  alsr_pkg::sts_t sts,
  output alsr_pkg::cmd_t cmd
);
  import alsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DISP = 7'b0000010,
    S_SRD  = 7'b0000100,
    S_SCMP = 7'b0001000,
    S_SHRD = 7'b0010000,
    S_SHWR = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.clr_idx   = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if ((sts.op == OP_SEARCH || sts.op == OP_REMOVE) && !sts.cnt_zero) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        cmd.scan_cmp = 1'b1;
        if (sts.hit) begin
          if (sts.op == OP_REMOVE && sts.more) begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_SHRD;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (sts.more) begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_SRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SHRD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        cmd.shift_wr = 1'b1;
        if (sts.more) begin
          cmd.inc_idx = 1'b1;
          state_nxt   = S_SHRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/array_list_search_remove.sv
// Array list with append insert, linear key search and remove with shift-down.
// One transaction is worked on at a time; the next is taken while the previous result
// still waits in the output register. An insert only dispatches and finishes. A search
// reads and compares the entries in turn up to the first match; a remove then reads
// each later entry and writes it one place down. All steps go through one 128-entry RAM
// with registered read, so each entry is read before it is compared or moved.
// Entries need no clearing after reset: only positions below the count are read.
module array_list_search_remove (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  alsr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output alsr_pkg::out_item_t out_data
);
  import alsr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  alsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  alsr_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> hdl/alsr_checker.sv
// Port-level checker for the array list search and remove block, with its bind.
`include "array_list_search_remove_assert.svh"

module alsr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input alsr_pkg::out_item_t out_data
);
  import alsr_pkg::*;

  logic out_stall;
  logic miss;
  logic zero_fields;
  logic full_rsp;
  logic count_max;

  assign out_stall   = out_valid && !out_ready;
  assign miss        = (out_data.status == ST_FULL) || (out_data.status == ST_NOT_FOUND);
  assign zero_fields = (out_data.position == '0) && (out_data.entry_age == '0);
  assign full_rsp    = out_valid && (out_data.status == ST_FULL);
  assign count_max   = (out_data.entry_count == COUNT_W'(LIST_DEPTH));

  `ALSR_ASSERT_NXT(a_out_valid_holds, out_stall, out_valid)
  `ALSR_ASSERT_NXT(a_out_data_holds, out_stall, $stable(out_data))
  `ALSR_ASSERT_IMP(a_miss_zero_fields, out_valid && miss, zero_fields)
  `ALSR_ASSERT_IMP(a_full_count, full_rsp, count_max)
  `ALSR_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

bind array_list_search_remove alsr_checker u_alsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
